### rtl/ccls_pkg.sv
// ----------------------------------------------------------------------------
// ccls_pkg
// Shared constants, codes and types of the closest-centre layer selector.
// ----------------------------------------------------------------------------
package ccls_pkg;

   // Geometry of the block
   localparam int MAX_LAYERS  = 8;
   localparam int COORD_BITS  = 24;
   localparam int LAYER_BITS  = 3;
   localparam int MASK_BITS   = 8;
   localparam int TREE_LEAVES = 8;

   // Distance limit and derived widths
   localparam int DIST_LIMIT = 1000000;
   localparam int DIST_BITS  = $clog2(DIST_LIMIT);
   localparam int SQ_BITS    = 2 * DIST_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int ABS_BITS   = (DIFF_BITS > DIST_BITS) ? DIFF_BITS : DIST_BITS;

   localparam logic [SUM_BITS-1:0] LIMIT_SQ =
      SUM_BITS'(64'(DIST_LIMIT) * 64'(DIST_LIMIT));

   // Word kinds on the request channel
   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // Result of one distance lane
   typedef struct packed {
      logic                ok;
      logic [SUM_BITS-1:0] sq_dist;
   } lane_res_type;

   // Candidate travelling through the minimum tree
   typedef struct packed {
      logic                  ok;
      logic [SUM_BITS-1:0]   sq_dist;
      logic [LAYER_BITS-1:0] idx;
   } cand_type;

   // a is always the lower layer, so it keeps ties
   function automatic cand_type pick_nearer(cand_type a, cand_type b);
      cand_type r;
      if (b.ok && (!a.ok || (b.sq_dist < a.sq_dist))) r = b;
      else r = a;
      return r;
   endfunction

endpackage

### rtl/ccls_req_if.sv
// ----------------------------------------------------------------------------
// ccls_req_if
// Request channel: centre loads and pixel queries.
// ----------------------------------------------------------------------------
interface ccls_req_if
   import ccls_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [LAYER_BITS-1:0]        layer_index;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;
   logic [MASK_BITS-1:0]         eligible_mask;

   modport source (output valid, action, layer_index, x_coord, y_coord, eligible_mask,
                   input ready);
   modport sink   (input valid, action, layer_index, x_coord, y_coord, eligible_mask,
                   output ready);
endinterface

### rtl/ccls_rsp_if.sv
// ----------------------------------------------------------------------------
// ccls_rsp_if
// Response channel: selected layer and found flag.
// ----------------------------------------------------------------------------
interface ccls_rsp_if
   import ccls_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [LAYER_BITS-1:0] chosen_layer;
   logic                  found;

   modport source (output valid, chosen_layer, found, input ready);
   modport sink   (input valid, chosen_layer, found, output ready);
endinterface

### rtl/ccls_dist_lane.sv
// ----------------------------------------------------------------------------
// ccls_dist_lane
// Squared distance from the pixel to one layer centre, three stages deep:
// absolute differences, squares, sum and limit check.
// ----------------------------------------------------------------------------
module ccls_dist_lane
   import ccls_pkg::*;
(
   input  logic                         clock,
   input  logic                         advance,
   input  logic                         lane_en,
   input  logic signed [COORD_BITS-1:0] pixel_x,
   input  logic signed [COORD_BITS-1:0] pixel_y,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   output lane_res_type                 res
);

   logic signed [DIFF_BITS-1:0] diff_x, diff_y;
   logic [ABS_BITS-1:0]         abs_x, abs_y;
   logic                        near_in;

   logic [DIST_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic                 en1_ff;
   logic [SQ_BITS-1:0]   sqx_ff, sqy_ff;
   logic                 en2_ff;
   logic [SUM_BITS-1:0]  sum_in;
   lane_res_type         res_ff, res_in;

   // Stage A: absolute differences and far check
   always_comb begin
      diff_x  = DIFF_BITS'(pixel_x) - DIFF_BITS'(center_x);
      diff_y  = DIFF_BITS'(pixel_y) - DIFF_BITS'(center_y);
      abs_x   = ABS_BITS'(unsigned'(diff_x[DIFF_BITS-1] ? -diff_x : diff_x));
      abs_y   = ABS_BITS'(unsigned'(diff_y[DIFF_BITS-1] ? -diff_y : diff_y));
      near_in = (abs_x < ABS_BITS'(DIST_LIMIT)) && (abs_y < ABS_BITS'(DIST_LIMIT));
      dx_in   = abs_x[DIST_BITS-1:0];
      dy_in   = abs_y[DIST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         en1_ff <= lane_en && near_in;
      end
   end

   // Stage B: squares
   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
         sqy_ff <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
         en2_ff <= en1_ff;
      end
   end

   // Stage C: sum and limit compare
   always_comb begin
      sum_in         = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
      res_in.sq_dist = sum_in;
      res_in.ok      = en2_ff && (sum_in < LIMIT_SQ);
   end

   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

### rtl/ccls_min_tree.sv
// ----------------------------------------------------------------------------
// ccls_min_tree
// Registered three-level minimum tree over the lane distances; the lower
// layer keeps a tie. The last level is the response register.
// ----------------------------------------------------------------------------
module ccls_min_tree
   import ccls_pkg::*;
(
   input  logic                  clock,
   input  logic                  advance,
   input  lane_res_type          leaves [TREE_LEAVES],
   output logic [LAYER_BITS-1:0] chosen_layer,
   output logic                  found
);

   cand_type leaf_cand [TREE_LEAVES];
   cand_type lvl1_ff [4];
   cand_type lvl1_in [4];
   cand_type lvl2_ff [2];
   cand_type lvl2_in [2];
   cand_type best_ff, best_in;

   // Tag each leaf with its layer number
   always_comb begin
      for (int i = 0; i < TREE_LEAVES; i++) begin
         leaf_cand[i].ok      = leaves[i].ok;
         leaf_cand[i].sq_dist = leaves[i].sq_dist;
         leaf_cand[i].idx     = LAYER_BITS'(i);
      end
   end

   // Pairwise selection, one level per stage
   always_comb begin
      for (int i = 0; i < 4; i++) lvl1_in[i] = pick_nearer(leaf_cand[2*i], leaf_cand[2*i+1]);
      for (int i = 0; i < 2; i++) lvl2_in[i] = pick_nearer(lvl1_ff[2*i], lvl1_ff[2*i+1]);
      best_in = pick_nearer(lvl2_ff[0], lvl2_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lvl1_ff <= lvl1_in;
         lvl2_ff <= lvl2_in;
         best_ff <= best_in;
      end
   end

   // Nothing in range reports layer zero
   assign found        = best_ff.ok;
   assign chosen_layer = best_ff.ok ? best_ff.idx : '0;

endmodule

### rtl/closest_center_layer_select.sv
// A query word passes the input register, the lane stages and then the tree levels.
// Throughput: one word per cycle; the whole pipeline holds while a response stalls.
// Load words give no response; a stored centre is seen by the next query word.
// Reset clears the stage valid bits only; the centre table is not cleared.
// ----------------------------------------------------------------------------
// closest_center_layer_select
// Mosaic pixel selector: per query, the eligible layer whose centre lies
// nearest by squared distance, within the distance limit.
// ----------------------------------------------------------------------------
module closest_center_layer_select
   import ccls_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ccls_req_if.sink   req_bus,
   ccls_rsp_if.source rsp_bus
);

   localparam int DEPTH = 7;

   logic advance;
   logic req_take;
   logic [DEPTH-1:0] valid_ff, valid_in;

   logic signed [COORD_BITS-1:0] center_x_ff [MAX_LAYERS];
   logic signed [COORD_BITS-1:0] center_y_ff [MAX_LAYERS];

   logic signed [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic [MASK_BITS-1:0]         mask_ff;

   lane_res_type leaves [TREE_LEAVES];

   // Global stall: everything moves when the response register can move
   assign advance       = !valid_ff[DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign req_take      = req_bus.valid && advance;

   // Centre table, written straight from the request word
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         if (req_take && (req_bus.action == ACT_LOAD) &&
             (req_bus.layer_index == LAYER_BITS'(i))) begin
            center_x_ff[i] <= req_bus.x_coord;
            center_y_ff[i] <= req_bus.y_coord;
         end
      end
   end

   // Input stage for query words
   always_ff @(posedge clock) begin
      if (advance) begin
         pix_x_ff <= req_bus.x_coord;
         pix_y_ff <= req_bus.y_coord;
         mask_ff  <= req_bus.eligible_mask;
      end
   end

   // Valid bits travel alongside the data
   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_take && (req_bus.action == ACT_QUERY)};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= valid_in;
   end

   // Distance lanes; spare tree leaves never win
   for (genvar g = 0; g < TREE_LEAVES; g++) begin : g_lane
      if (g < MAX_LAYERS) begin : g_used
         ccls_dist_lane u_lane (
            .clock    (clock),
            .advance  (advance),
            .lane_en  (mask_ff[g]),
            .pixel_x  (pix_x_ff),
            .pixel_y  (pix_y_ff),
            .center_x (center_x_ff[g]),
            .center_y (center_y_ff[g]),
            .res      (leaves[g])
         );
      end else begin : g_spare
         assign leaves[g] = '0;
      end
   end

   ccls_min_tree u_tree (
      .clock        (clock),
      .advance      (advance),
      .leaves       (leaves),
      .chosen_layer (rsp_bus.chosen_layer),
      .found        (rsp_bus.found)
   );

   assign rsp_bus.valid = valid_ff[DEPTH-1];

   // A miss always reports layer zero
   a_miss_layer_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.chosen_layer == '0))
      else $error("miss response with non-zero layer");

   // Load words never enter the pipeline
   a_load_no_word: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_bus.action == ACT_LOAD)) |=> !valid_ff[0])
      else $error("load word produced a pipeline word");

   // A load of layer zero lands in the table
   a_load_stored: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_bus.action == ACT_LOAD) && (req_bus.layer_index == '0))
      |=> (center_x_ff[0] == $past(req_bus.x_coord)) &&
          (center_y_ff[0] == $past(req_bus.y_coord)))
      else $error("centre load not stored");

   // A stall freezes the valid chain
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("valid chain moved during stall");

endmodule
